[src/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types for the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int unsigned AXES = 3;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} rbs_ray_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} rbs_res_t;

	// control bits that ride alongside the division lanes
	typedef struct packed {
		logic            valid;
		logic            pmiss;   // a parallel axis has the origin outside its slab
		logic [AXES-1:0] np;      // axis is not parallel, its distances count
	} rbs_side_t;

endpackage

[src/rbs_div_lane.sv]
// ----------------------------------------------------------------------------
// rbs_div_lane
// Pipelined restoring divider, one quotient bit per stage, signed result
// truncated toward zero.
// ----------------------------------------------------------------------------
module rbs_div_lane #(
	parameter int NB = 49
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NB-1:0]        num,
	input  logic [31:0]          den,
	input  logic                 neg,
	output logic signed [NB:0]   quo
);

	logic [31:0]   r_s   [NB];
	logic [NB-1:0] n_s   [NB];
	logic [31:0]   d_s   [NB];
	logic          neg_s [NB];

	genvar k;
	generate
		for (k = 0; k < NB; k++) begin : g_stage
			logic [31:0]   r_in;
			logic [NB-1:0] n_in;
			logic [31:0]   d_in;
			logic          neg_in;
			logic [32:0]   tr;
			logic          ge;

			if (k == 0) begin : g_first
				assign r_in   = '0;
				assign n_in   = num;
				assign d_in   = den;
				assign neg_in = neg;
			end else begin : g_next
				assign r_in   = r_s[k-1];
				assign n_in   = n_s[k-1];
				assign d_in   = d_s[k-1];
				assign neg_in = neg_s[k-1];
			end

			assign tr = {r_in, n_in[NB-1]};
			assign ge = tr >= {1'b0, d_in};

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k]   <= ge ? 32'(tr - {1'b0, d_in}) : tr[31:0];
					n_s[k]   <= {n_in[NB-2:0], ge};
					d_s[k]   <= d_in;
					neg_s[k] <= neg_in;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[NB-1] ? -$signed({1'b0, n_s[NB-1]}) : $signed({1'b0, n_s[NB-1]});
		end
	end

endmodule

[src/rbs_reduce.sv]
// ----------------------------------------------------------------------------
// rbs_reduce
// Orders each slab's two distances, then narrows them to one interval.
// ----------------------------------------------------------------------------
module rbs_reduce
	import rbs_pkg::*;
#(
	parameter int QW = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rbs_side_t            side_in,
	input  logic signed [QW-1:0] t_a [AXES],
	input  logic signed [QW-1:0] t_b [AXES],
	output rbs_side_t            side_out,
	output logic signed [QW-1:0] tmin,
	output logic signed [QW-1:0] tmax
);

	rbs_side_t            side_s1;
	logic signed [QW-1:0] lo_s1 [AXES];
	logic signed [QW-1:0] hi_s1 [AXES];
	logic signed [QW-1:0] tmin_c, tmax_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_out <= '0;
		end else if (en) begin
			side_s1  <= side_in;
			side_out <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				lo_s1[a] <= (t_a[a] > t_b[a]) ? t_b[a] : t_a[a];
				hi_s1[a] <= (t_a[a] > t_b[a]) ? t_a[a] : t_b[a];
			end
			tmin <= tmin_c;
			tmax <= tmax_c;
		end
	end

	// only non-parallel axes narrow; an empty set is flagged by np == 0 downstream
	always_comb begin
		tmin_c = '0;
		tmax_c = '0;
		for (int a = AXES - 1; a >= 0; a--) begin
			if (side_s1.np[a]) begin
				tmin_c = lo_s1[a];
				tmax_c = hi_s1[a];
			end
		end
		for (int a = 0; a < AXES; a++) begin
			if (side_s1.np[a]) begin
				if (lo_s1[a] > tmin_c) tmin_c = lo_s1[a];
				if (hi_s1[a] < tmax_c) tmax_c = hi_s1[a];
			end
		end
	end

endmodule

[src/ray_box_slab_intersect.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box test, slab method, signed fixed point.
// ----------------------------------------------------------------------------
// Takes one ray/box beat per cycle while the output is not stalled, and
// returns one result beat for each, in order. The path is one input register,
// six pipelined restoring dividers of FRAC_BITS + 33 one-bit stages plus a
// sign stage, two interval stages and the output register. The quotient
// width of the slab divisions sets the depth. A stall at the output freezes
// the whole pipeline and is passed straight back to the input.
module ray_box_slab_intersect
	import rbs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        ray_valid,
	output logic        ray_stall,
	input  rbs_ray_t    ray,
	output logic        res_valid,
	input  logic        res_stall,
	output rbs_res_t    res
);

	localparam int NB = 33 + FRAC_BITS;
	localparam int QW = NB + 1;
	localparam int SD = NB + 1;

	logic        adv;
	logic [15:0] eps_q;
	logic        v_s1;
	rbs_ray_t    ray_s1;

	logic signed [31:0] o [AXES];
	logic signed [31:0] d [AXES];
	logic signed [31:0] lo [AXES];
	logic signed [31:0] hi [AXES];

	logic [NB-1:0]        num_a [AXES];
	logic [NB-1:0]        num_b [AXES];
	logic                 neg_a [AXES];
	logic                 neg_b [AXES];
	logic [31:0]          dmag  [AXES];
	logic signed [QW-1:0] q_a   [AXES];
	logic signed [QW-1:0] q_b   [AXES];

	rbs_side_t            side_in;
	rbs_side_t            side_s [SD];
	rbs_side_t            side_r;
	logic signed [QW-1:0] tmin, tmax;

	logic        miss;
	logic        bounded;
	logic signed [QW-1:0] t_sel;

	assign adv       = !(res_valid && res_stall);
	assign ray_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ray_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1 <= ray;
		end
	end

	assign o  = '{ray_s1.origin_x, ray_s1.origin_y, ray_s1.origin_z};
	assign d  = '{ray_s1.dir_x, ray_s1.dir_y, ray_s1.dir_z};
	assign lo = '{ray_s1.box_min_x, ray_s1.box_min_y, ray_s1.box_min_z};
	assign hi = '{ray_s1.box_max_x, ray_s1.box_max_y, ray_s1.box_max_z};

	always_comb begin
		logic signed [32:0] df_a, df_b;
		logic [32:0]        mg_a, mg_b;
		side_in.valid = v_s1;
		side_in.pmiss = 1'b0;
		side_in.np    = '0;
		for (int a = 0; a < AXES; a++) begin
			df_a     = {lo[a][31], lo[a]} - {o[a][31], o[a]};
			df_b     = {hi[a][31], hi[a]} - {o[a][31], o[a]};
			mg_a     = df_a[32] ? 33'(-df_a) : 33'(df_a);
			mg_b     = df_b[32] ? 33'(-df_b) : 33'(df_b);
			num_a[a] = {mg_a, {FRAC_BITS{1'b0}}};
			num_b[a] = {mg_b, {FRAC_BITS{1'b0}}};
			neg_a[a] = df_a[32] ^ d[a][31];
			neg_b[a] = df_b[32] ^ d[a][31];
			dmag[a]  = d[a][31] ? 32'(-d[a]) : 32'(d[a]);
			side_in.np[a] = dmag[a] > {16'b0, eps_q};
			if (!side_in.np[a] && (o[a] < lo[a] || o[a] > hi[a])) side_in.pmiss = 1'b1;
		end
	end

	genvar a;
	generate
		for (a = 0; a < AXES; a++) begin : g_axis
			rbs_div_lane #(.NB(NB)) u_div_a (
				.clk (clk),
				.en  (adv),
				.num (num_a[a]),
				.den (dmag[a]),
				.neg (neg_a[a]),
				.quo (q_a[a])
			);
			rbs_div_lane #(.NB(NB)) u_div_b (
				.clk (clk),
				.en  (adv),
				.num (num_b[a]),
				.den (dmag[a]),
				.neg (neg_b[a]),
				.quo (q_b[a])
			);
		end
	endgenerate

	// flags follow the divider lanes stage for stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SD; k++) side_s[k] <= '0;
		end else if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < SD; k++) side_s[k] <= side_s[k-1];
		end
	end

	rbs_reduce #(.QW(QW)) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.side_in  (side_s[SD-1]),
		.t_a      (q_a),
		.t_b      (q_b),
		.side_out (side_r),
		.tmin     (tmin),
		.tmax     (tmax)
	);

	assign bounded = |side_r.np;
	assign miss    = side_r.pmiss || (bounded && (tmax < 0 || tmin > tmax));
	assign t_sel   = (bounded && tmin >= 0) ? tmin : tmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= side_r.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (miss) begin
				res.hit      <= 1'b0;
				res.distance <= '0;
			end else begin
				res.hit <= 1'b1;
				// unbounded interval or a distance past 31 bits saturates
				if (!bounded || (|t_sel[QW-1:31])) res.distance <= '1;
				else res.distance <= t_sel[30:0];
			end
		end
	end

endmodule

[src/rbs_checker.sv]
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the ray versus box slab test.
// ----------------------------------------------------------------------------
module rbs_checker
	import rbs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     ray_valid,
	input logic     ray_stall,
	input logic     res_valid,
	input logic     res_stall,
	input rbs_res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.distance == '0)
		else $error("miss with nonzero distance");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && ray_stall |-> res_valid && res_stall)
		else $error("input stalled without output backpressure");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Ray versus box slab test bench: directed and random rays, checked in order.
// ----------------------------------------------------------------------------
// A local predictor computes the expected hit and distance of every ray
// accepted by the block. Result beats are compared in order against that
// queue. The sender runs in bursts with random gaps, and the receiver stalls
// on its own random pattern. Several epsilon settings are exercised.
module tb_top;
	import rbs_pkg::*;

	localparam int LATENCY = 54;
	localparam longint DIST_SAT = 64'h7FFFFFFF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic ray_valid;
	logic ray_stall;
	rbs_ray_t ray;
	logic res_valid;
	logic res_stall;
	rbs_res_t res;

	rbs_res_t hit_queue[$];
	logic [15:0] eps_shadow;
	int errors;
	int rays_sent;
	int results_seen;
	int hits_seen;
	bit long_hold;
	bit no_stall;

	ray_box_slab_intersect dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.ray_valid(ray_valid),
		.ray_stall(ray_stall),
		.ray(ray),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one axis of the slab test; returns 0 on a parallel miss
	function automatic bit narrow_slab(longint o, longint d, longint lo, longint hi,
			inout longint tmin, inout longint tmax);
		longint mag;
		longint t1;
		longint t2;
		longint x;
		mag = d < 0 ? -d : d;
		if (mag > longint'(eps_shadow)) begin
			t1 = ((lo - o) * 65536) / d;
			t2 = ((hi - o) * 65536) / d;
			if (t1 > t2) begin
				x = t1;
				t1 = t2;
				t2 = x;
			end
			if (t1 > tmin) tmin = t1;
			if (t2 < tmax) tmax = t2;
			return 1'b1;
		end
		return !(o < lo || o > hi);
	endfunction

	function automatic rbs_res_t predict_hit(rbs_ray_t r);
		longint tmin;
		longint tmax;
		longint t;
		bit ok;
		rbs_res_t p;
		tmin = -64'sh7FFFFFFFFFFFFFFF;
		tmax = 64'sh7FFFFFFFFFFFFFFF;
		ok = narrow_slab(r.origin_x, r.dir_x, r.box_min_x, r.box_max_x, tmin, tmax);
		if (ok) ok = narrow_slab(r.origin_y, r.dir_y, r.box_min_y, r.box_max_y, tmin, tmax);
		if (ok) ok = narrow_slab(r.origin_z, r.dir_z, r.box_min_z, r.box_max_z, tmin, tmax);
		if (ok && (tmax < 0 || tmin > tmax)) ok = 1'b0;
		p = '0;
		if (ok) begin
			t = tmin >= 0 ? tmin : tmax;
			if (t > DIST_SAT) t = DIST_SAT;
			p.hit = 1'b1;
			p.distance = t[30:0];
		end
		return p;
	endfunction

	// receiver: random stall pattern, optional long hold-off
	initial begin
		int hold;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_stall <= 1'b1;
				for (hold = 0; hold < 200; hold++) @(posedge clk);
				long_hold = 1'b0;
				res_stall <= 1'b0;
			end else if (no_stall) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rbs_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (hit_queue.size() == 0) begin
				$error("result beat with nothing expected: hit %0b distance %0h",
					res.hit, res.distance);
				errors++;
			end else begin
				want = hit_queue.pop_front();
				if (res.hit !== want.hit) begin
					$error("hit: expected %0b actual %0b", want.hit, res.hit);
					errors++;
				end
				if (res.distance !== want.distance) begin
					$error("distance: expected %0h actual %0h", want.distance, res.distance);
					errors++;
				end
				if (res.hit === 1'b1) hits_seen++;
			end
		end
	end

	int burst_left;

	// send one ray beat; the sender idles between random bursts
	task automatic send_ray(rbs_ray_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				ray_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		ray_valid <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
		hit_queue.insert(hit_queue.size(), predict_hit(r));
		rays_sent++;
		burst_left--;
	endtask

	task automatic drain();
		ray_valid <= 1'b0;
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		eps_shadow = v;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			default: return $signed($urandom_range(0, 200)) - 100;
		endcase
	endfunction

	// a ray likely to hit: origin in front of a box, direction toward it
	function automatic rbs_ray_t aimed_ray();
		rbs_ray_t r;
		int m;
		m = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 5) == 0 ? 2 : 1);
		r.origin_x = rand_coord(m);
		r.origin_y = rand_coord(m);
		r.origin_z = rand_coord(m);
		r.box_min_x = rand_coord(m);
		r.box_min_y = rand_coord(m);
		r.box_min_z = rand_coord(m);
		r.box_max_x = r.box_min_x + $urandom_range(0, 8 << 16);
		r.box_max_y = r.box_min_y + $urandom_range(0, 8 << 16);
		r.box_max_z = r.box_min_z + $urandom_range(0, 8 << 16);
		r.dir_x = ((r.box_min_x >>> 1) - (r.origin_x >>> 1)) + $signed($urandom_range(0, 4096)) - 2048;
		r.dir_y = ((r.box_min_y >>> 1) - (r.origin_y >>> 1)) + $signed($urandom_range(0, 4096)) - 2048;
		r.dir_z = ((r.box_min_z >>> 1) - (r.origin_z >>> 1)) + $signed($urandom_range(0, 4096)) - 2048;
		if ($urandom_range(0, 7) == 0) r.dir_x = $signed($urandom_range(0, 64)) - 32;
		if ($urandom_range(0, 7) == 0) r.dir_y = 0;
		if ($urandom_range(0, 3) == 0) begin
			r.box_min_z = r.box_max_z;
			r.box_max_z = r.box_min_z - $urandom_range(0, 4 << 16);
		end
		return r;
	endfunction

	function automatic rbs_ray_t noise_ray();
		rbs_ray_t r;
		r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		return r;
	endfunction

	task automatic test_directed();
		rbs_ray_t r;
		// axis-aligned hit from outside
		r = '0;
		r.origin_x = -(5 << 16);
		r.dir_x = 1 << 16;
		r.box_min_x = -(1 << 16); r.box_max_x = 1 << 16;
		r.box_min_y = -(1 << 16); r.box_max_y = 1 << 16;
		r.box_min_z = -(1 << 16); r.box_max_z = 1 << 16;
		send_ray(r);
		// origin inside: distance is the exit
		r.origin_x = 0;
		send_ray(r);
		// pointing away: miss
		r.origin_x = 5 << 16;
		send_ray(r);
		// all axes parallel, inside: unbounded interval saturates
		r.dir_x = 0;
		r.origin_x = 0;
		send_ray(r);
		// parallel, outside
		r.origin_y = 2 << 16;
		send_ray(r);
		// inverted box on a parallel axis always misses
		r.origin_y = 0;
		r.box_min_z = 1 << 16; r.box_max_z = -(1 << 16);
		send_ray(r);
		// inverted box on a live axis acts swapped
		r.dir_z = -(1 << 16);
		r.origin_z = 4 << 16;
		send_ray(r);
		// far box, tiny direction: large distance saturates
		r = '0;
		r.dir_x = 1;
		r.box_min_x = 32'sh7FFF0000; r.box_max_x = 32'sh7FFFFFFF;
		r.box_min_y = -1; r.box_max_y = 1;
		r.box_min_z = -1; r.box_max_z = 1;
		send_ray(r);
		// field extremes
		r = '1;
		send_ray(r);
		r = {12{32'h80000000}};
		send_ray(r);
		r = {12{32'h7FFFFFFF}};
		send_ray(r);
		r = {6{32'h80000000, 32'h7FFFFFFF}};
		send_ray(r);
		r = {6{32'h7FFFFFFF, 32'h80000000}};
		send_ray(r);
		r.dir_x = 32'h80000000; r.dir_y = 32'h7FFFFFFF; r.dir_z = 32'hFFFFFFFF;
		send_ray(r);
	endtask

	task automatic test_epsilon_edge(logic [15:0] v);
		rbs_ray_t r;
		write_epsilon(v);
		r = aimed_ray();
		r.dir_x = 32'(v);
		send_ray(r);
		r.dir_x = -$signed({16'b0, v});
		send_ray(r);
		r.dir_x = v + 1;
		send_ray(r);
		r.dir_y = -$signed({16'b0, v}) - 1;
		send_ray(r);
	endtask

	task automatic test_random(int count);
		repeat (count) send_ray($urandom_range(0, 4) == 0 ? noise_ray() : aimed_ray());
	endtask

	task automatic test_backpressure();
		drain();
		long_hold = 1'b1;
		test_random(120);
		no_stall = 1'b1;
		test_random(80);
		no_stall = 1'b0;
	endtask

	initial begin
		errors = 0;
		rays_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		burst_left = 0;
		long_hold = 1'b0;
		no_stall = 1'b0;
		eps_shadow = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		ray_valid = 1'b0;
		ray = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_epsilon_edge(16'hFFFF);
		test_random(250);
		test_epsilon_edge(16'h0400);
		test_random(250);
		test_epsilon_edge(16'h5AA5);
		test_random(150);
		test_epsilon_edge(16'h0000);
		test_random(150);
		test_backpressure();
		drain();
		$display("rays sent %0d, results %0d, hits %0d", rays_sent, results_seen, hits_seen);
		$display("covered parallel, inverted, saturated and extreme rays over five epsilons");
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
